// ===== hdl/ftrm_pkg.sv =====
// Shared types and constants for the fan tachometer rpm meter.
package ftrm_pkg;

  localparam int unsigned TimerW = 48;
  localparam int unsigned CntW   = 8;
  localparam int unsigned RpmW   = 16;
  localparam int unsigned TmoW   = 30;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumW   = 44;   // 60e9 * 254 fits in 44 bits

  localparam logic [35:0] NsPerMinute = 36'd60000000000;
  localparam logic [CntW-1:0] EdgeLimitReset = 8'd33;
  localparam logic [TmoW-1:0] TimeoutReset   = 30'd500000000;

  localparam logic [CfgIdxW-1:0] CfgEdgeLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 2'd1;

  typedef struct packed {
    logic              cmd;
    logic              tach_level;
    logic [TimerW-1:0] timer_ns;
  } in_item_t;

  typedef struct packed {
    logic [RpmW-1:0] rpm;
    logic            error;
  } out_item_t;

  // finished measurement handed from front to back
  typedef struct packed {
    logic [CntW-1:0]   revs;
    logic [TimerW-1:0] elapsed;
  } job_t;

endpackage

// ===== hdl/ftrm_front.sv =====
// Front end: tracks the measurement and emits a job when it ends.
module ftrm_front import ftrm_pkg::*; #(
  parameter int unsigned TIMER_BITS    = 48,
  parameter int unsigned EDGES_PER_REV = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  input  logic [CntW-1:0]     edge_limit_i,
  input  logic [TmoW-1:0]     timeout_i,
  input  logic                full_i,
  output logic                push_o,
  output job_t                job_o
);

  localparam int unsigned ElW = (TIMER_BITS < TimerW) ? TIMER_BITS : TimerW;
  localparam logic [TimerW-1:0] TMask =
    (ElW >= TimerW) ? '1 : ((48'd1 << ElW) - 48'd1);
  // floor(x / EDGES_PER_REV) as (x * RecipMul) >> RecipShift, exact for x below 256
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'((2**RecipShift + EDGES_PER_REV - 1) / EDGES_PER_REV);

  logic              meas_q, meas_d;
  logic              prev_q, prev_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TimerW-1:0] start_q, start_d;

  logic                   accept;
  logic [TimerW-1:0]      now;
  logic                   borrow;
  logic [TimerW-1:0]      elapsed;
  logic [CntW-1:0]        cnt_inc;
  logic [CntW+RecipW-1:0] revs_prod;
  logic [CntW-1:0]        revs;
  logic                   done;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  assign now     = in_data_i.timer_ns & TMask;
  assign borrow  = (now < start_q);
  // a timer wider than the sample wraps far past any timeout; the rate rounds to zero
  assign elapsed = ((TIMER_BITS > TimerW) && borrow) ? '1 : ((now - start_q) & TMask);
  assign cnt_inc = ((in_data_i.tach_level != prev_q) && (cnt_q != '1)) ?
                   cnt_q + 8'd1 : cnt_q;
  assign done    = ~((cnt_inc < edge_limit_i) &&
                     (elapsed < {{(TimerW-TmoW){1'b0}}, timeout_i}));
  assign revs_prod = {{RecipW{1'b0}}, cnt_inc - 8'd1} * {{CntW{1'b0}}, RecipMul};
  assign revs    = (cnt_inc == '0) ? '0 : revs_prod[RecipShift +: CntW];

  assign push_o        = accept & ~in_data_i.cmd & meas_q & done;
  assign job_o.revs    = revs;
  assign job_o.elapsed = elapsed;

  always_comb begin
    meas_d  = meas_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    if (accept) begin
      if (in_data_i.cmd) begin
        meas_d  = 1'b1;
        prev_d  = in_data_i.tach_level;
        cnt_d   = '0;
        start_d = now;
      end else if (meas_q) begin
        prev_d = in_data_i.tach_level;
        cnt_d  = cnt_inc;
        if (done) begin
          meas_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q  <= 1'b0;
      prev_q  <= 1'b0;
      cnt_q   <= '0;
      start_q <= '0;
    end else begin
      meas_q  <= meas_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
  end

endmodule

// ===== hdl/ftrm_queue.sv =====
// Two-entry job queue between front and back.
module ftrm_queue import ftrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/ftrm_div.sv =====
// Back end: rpm scaling, saturation and restoring division, output register.
module ftrm_div import ftrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCheck,
    StDiv,
    StFin
  } state_e;

  localparam int unsigned DshW = TimerW + RpmW;

  state_e            state_q, state_d;
  logic [CntW-1:0]   revs_q, revs_d;
  logic [TimerW-1:0] den_q, den_d;
  logic [NumW-1:0]   rem_q, rem_d;
  logic [DshW-1:0]   dsh_q, dsh_d;
  logic [RpmW-1:0]   quo_q, quo_d;
  logic              err_q, err_d;
  logic [3:0]        step_q, step_d;
  logic              ovld_q, ovld_d;
  out_item_t         odat_q, odat_d;

  logic              out_free;
  logic              ge;

  assign out_free    = ~ovld_q | ~out_stall_i;
  assign pop_o       = (state_q == StIdle) & ~empty_i;
  assign out_valid_o = ovld_q;
  assign out_data_o  = odat_q;
  assign ge          = {{(DshW-NumW){1'b0}}, rem_q} >= dsh_q;

  always_comb begin
    state_d = state_q;
    revs_d  = revs_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    err_d   = err_q;
    step_d  = step_q;
    ovld_d  = ovld_q & out_stall_i;
    odat_d  = odat_q;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          revs_d  = job_i.revs;
          den_d   = job_i.elapsed;
          state_d = StMul;
        end
      end
      StMul: begin
        rem_d   = {{(NumW-36){1'b0}}, NsPerMinute} * {{(NumW-CntW){1'b0}}, revs_q};
        err_d   = (den_q == '0);
        state_d = StCheck;
      end
      StCheck: begin
        quo_d  = '0;
        step_d = 4'd15;
        dsh_d  = {1'b0, den_q, {(RpmW-1){1'b0}}};
        if (err_q) begin
          state_d = StFin;
        end else if ({{(DshW-NumW){1'b0}}, rem_q} >= {den_q, {RpmW{1'b0}}}) begin
          quo_d   = '1;
          state_d = StFin;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (ge) begin
          rem_d = rem_q - NumW'(dsh_q);
        end
        quo_d  = {quo_q[RpmW-2:0], ge};
        dsh_d  = dsh_q >> 1;
        step_d = step_q - 4'd1;
        if (step_q == 4'd0) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          ovld_d       = 1'b1;
          odat_d.rpm   = quo_q;
          odat_d.error = err_q;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
      revs_q  <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      dsh_q   <= '0;
      quo_q   <= '0;
      err_q   <= 1'b0;
      step_q  <= '0;
      odat_q  <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      revs_q  <= revs_d;
      den_q   <= den_d;
      rem_q   <= rem_d;
      dsh_q   <= dsh_d;
      quo_q   <= quo_d;
      err_q   <= err_d;
      step_q  <= step_d;
      odat_q  <= odat_d;
    end
  end

endmodule

// ===== hdl/fan_tach_rpm_meter.sv =====
// Fan tachometer rpm meter: top level with configuration registers.
// Samples and starts are taken one per cycle while the two-entry job queue has room.
// A job moves from the queue through the back end's idle, multiply, check, divide and finish
// states into the output register (skipping divide on error or saturation), one job at a time.
// Reset (async, active low) idles the meter, empties the queue and output register,
// and loads edge_limit = 33 and timeout_ns = 500000000.
module fan_tach_rpm_meter import ftrm_pkg::*; #(
  parameter int unsigned TIMER_BITS    = 48,
  parameter int unsigned EDGES_PER_REV = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TmoW-1:0]    cfg_data_i
);

  logic [CntW-1:0] edge_limit_q;
  logic [TmoW-1:0] timeout_q;

  logic push, pop, full, empty;
  job_t push_job, head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_limit_q <= EdgeLimitReset;
      timeout_q    <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgEdgeLimit: edge_limit_q <= cfg_data_i[CntW-1:0];
        CfgTimeout:   timeout_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  ftrm_front #(
    .TIMER_BITS    (TIMER_BITS),
    .EDGES_PER_REV (EDGES_PER_REV)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .edge_limit_i (edge_limit_q),
    .timeout_i    (timeout_q),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  ftrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  ftrm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== bench/tb_fan_tach_rpm_meter.sv =====
// Self-checking testbench for the fan tachometer rpm meter: directed table plus random phases.
`timescale 1ns / 1ps

module tb_fan_tach_rpm_meter;
  import ftrm_pkg::*;

  localparam int unsigned EdgesPerRev   = 4;
  localparam int unsigned SettleCycles  = 32;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PhaseItems    = 125;
  localparam int unsigned HoldPhase     = 3;
  localparam int unsigned PausePhase    = 5;
  localparam logic [TimerW-1:0] TimerMax = '1;
  localparam logic [TmoW-1:0]   TmoMax   = '1;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  // one row of the directed table: either a register write or an input transfer
  typedef struct packed {
    logic              is_cfg;
    logic              typed;
    in_item_t          item;
    out_item_t         res;
    logic [CfgIdxW-1:0] idx;
    logic [TmoW-1:0]   val;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TmoW-1:0]    cfg_data;

  // predictor state and its copy of the registers
  logic              mtr_active;
  logic              mtr_level;
  logic [CntW-1:0]   mtr_edges;
  logic [TimerW-1:0] mtr_start;
  logic [CntW-1:0]   cfg_edge_limit;
  logic [TmoW-1:0]   cfg_timeout;

  out_item_t   pending_speeds[$];
  stim_row_t   stim_table[$];
  int unsigned fail_count;
  int unsigned active_items;
  int unsigned quiet_cycles;
  bit          hold_req;

  fan_tach_rpm_meter #(
    .TIMER_BITS   (TimerW),
    .EDGES_PER_REV(EdgesPerRev)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [RpmW-1:0] rpm_from(input logic [CntW-1:0] edges,
                                               input logic [TimerW-1:0] elapsed);
    logic [63:0] revs;
    logic [63:0] quot;
    if (edges == '0) return '0;
    revs = ({56'd0, edges} - 64'd1) / EdgesPerRev;
    quot = ({28'd0, NsPerMinute} * revs) / {16'd0, elapsed};
    return (quot > 64'd65535) ? '1 : quot[RpmW-1:0];
  endfunction

  function automatic bit meter_predict(input in_item_t it, output out_item_t res);
    logic [TimerW-1:0] elapsed;
    res = '0;
    if (it.cmd) begin
      mtr_level  = it.tach_level;
      mtr_start  = it.timer_ns;
      mtr_edges  = '0;
      mtr_active = 1'b1;
      return 1'b0;
    end
    if (!mtr_active) return 1'b0;
    if (it.tach_level != mtr_level) begin
      if (mtr_edges != '1) mtr_edges = mtr_edges + 1'b1;
      mtr_level = it.tach_level;
    end
    elapsed = it.timer_ns - mtr_start;
    if (mtr_edges < cfg_edge_limit && elapsed < {{(TimerW-TmoW){1'b0}}, cfg_timeout})
      return 1'b0;
    mtr_active = 1'b0;
    if (elapsed == '0) res.error = 1'b1;
    else res.rpm = rpm_from(mtr_edges, elapsed);
    return 1'b1;
  endfunction

  function automatic logic [TimerW-1:0] rand_timer();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom;
    lo = $urandom;
    return {hi[TimerW-33:0], lo};
  endfunction

  function automatic void add_item(input logic cmd, input logic lvl, input logic [TimerW-1:0] t,
                                   input logic typed, input logic [RpmW-1:0] rpm,
                                   input logic err);
    stim_row_t row;
    row = '0;
    row.typed = typed;
    row.item.cmd = cmd;
    row.item.tach_level = lvl;
    row.item.timer_ns = t;
    row.res.rpm = rpm;
    row.res.error = err;
    stim_table.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [TmoW-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    stim_table.push_back(row);
  endfunction

  // offer one item and hold it until the transfer; expectation is taken at the transfer
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_res);
    out_item_t res;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (it.cmd || mtr_active) active_items++;
    if (meter_predict(it, res)) pending_speeds.push_back(typed ? typed_res : res);
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TmoW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx == CfgEdgeLimit) cfg_edge_limit = val[CntW-1:0];
    else if (idx == CfgTimeout) cfg_timeout = val;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_item_t exp;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_speeds.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual rpm=%0d error=%0d",
                 $time, out_data.rpm, out_data.error);
        fail_count++;
      end else begin
        exp = pending_speeds.pop_front();
        if (out_data.rpm !== exp.rpm) begin
          $display("%0t: rpm mismatch: expected %0d, actual %0d", $time, exp.rpm, out_data.rpm);
          fail_count++;
        end
        if (out_data.error !== exp.error) begin
          $display("%0t: error flag mismatch: expected %0d, actual %0d",
                   $time, exp.error, out_data.error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : rx_pattern
    stall_mode_e mode;
    int unsigned left;
    mode = StallNone;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left = $urandom_range(4, 60);
        end
        left--;
        case (mode)
          StallNone:  out_stall <= 1'b0;
          StallLight: out_stall <= ($urandom_range(0, 99) < 25);
          StallHeavy: out_stall <= ($urandom_range(0, 99) < 70);
          default:    out_stall <= ((left % 8) < 5);
        endcase
      end
    end
  end

  initial begin : main_seq
    in_item_t          it;
    logic [CntW-1:0]   lim;
    logic [TmoW-1:0]   tmo;
    logic [TimerW-1:0] cur_time;
    logic              cur_level;
    logic [TimerW-1:0] t0;
    int unsigned       burst_left;
    int unsigned       seq_left;
    int unsigned       step_max;
    int unsigned       phase_base;
    int unsigned       pick;
    bit                paused;

    fail_count   = 0;
    active_items = 0;
    quiet_cycles = 0;
    hold_req     = 1'b0;
    mtr_active   = 1'b0;
    mtr_level    = 1'b0;
    mtr_edges    = '0;
    mtr_start    = '0;
    cfg_edge_limit = EdgeLimitReset;
    cfg_timeout    = TimeoutReset;
    cur_time  = '0;
    cur_level = 1'b0;
    seq_left  = 0;
    burst_left = 0;

    rst_ni    = 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, reset register values at first
    t0 = 48'h0123_4567_89AB;
    add_item(1'b0, 1'b1, 48'd5, 1'b0, '0, 1'b0);            // sample while idle
    add_item(1'b1, 1'b0, 48'd0, 1'b0, '0, 1'b0);            // start at timer zero
    add_item(1'b0, 1'b1, 48'd0, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b0, 48'd500000000, 1'b1, '0, 1'b0);    // timeout, under one rev
    add_item(1'b1, 1'b1, TimerMax, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, 48'd499999999, 1'b1, '0, 1'b0);    // wrapped timer, no edges
    add_cfg(CfgEdgeLimit, 30'd1);
    add_item(1'b1, 1'b0, 48'd1000, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, 48'd1000, 1'b1, '0, 1'b1);         // zero elapsed time
    add_cfg(CfgEdgeLimit, 30'd5);
    add_cfg(CfgTimeout, TmoMax);
    add_item(1'b1, 1'b1, 48'd7, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b0, 48'd8, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, 48'd9, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b0, 48'd10, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, 48'd11, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b0, 48'd12, 1'b1, '1, 1'b0);           // saturated rpm
    add_item(1'b1, 1'b0, t0, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, t0 + 48'd200000000, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b0, t0 + 48'd400000000, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, t0 + 48'd600000000, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b0, t0 + 48'd800000000, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, t0 + 48'd1000000000, 1'b0, '0, 1'b0);
    add_item(1'b1, 1'b0, 48'd100, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, 48'd150, 1'b0, '0, 1'b0);
    add_item(1'b1, 1'b1, 48'd160, 1'b0, '0, 1'b0);          // restart mid measurement
    add_cfg(CfgEdgeLimit, 30'd0);
    add_item(1'b0, 1'b1, 48'd2000160, 1'b0, '0, 1'b0);      // ends on first sample
    add_cfg(CfgTimeout, 30'd1);
    add_cfg(CfgEdgeLimit, 30'd255);
    add_item(1'b1, 1'b0, 48'h8000_0000_0000, 1'b0, '0, 1'b0);
    add_item(1'b0, 1'b1, 48'h8000_0000_0001, 1'b0, '0, 1'b0);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        drain_all();
        write_reg(stim_table[i].idx, stim_table[i].val);
      end else begin
        send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].res);
      end
    end

    // random phases, each under its own register setting
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) begin
        lim = '1;
        tmo = TmoMax;
      end else if (ph == 1) begin
        lim = EdgeLimitReset;
        tmo = TimeoutReset;
      end else if (ph == 2) begin
        lim = '0;
        tmo = '0;
      end else if (ph == HoldPhase) begin
        lim = 8'd1;
        tmo = 30'd1;
      end else begin
        pick = $urandom_range(0, 9);
        lim = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd1 : CntW'($urandom_range(2, 16));
        pick = $urandom_range(0, 9);
        if (pick == 0) tmo = TmoMax;
        else if (pick < 3) tmo = TmoW'($urandom_range(1, 5000));
        else tmo = TmoW'($urandom_range(1000000, 300000000));
      end
      drain_all();
      write_reg(CfgEdgeLimit, {{(TmoW-CntW){1'b0}}, lim});
      write_reg(CfgTimeout, tmo);
      step_max = (cfg_timeout == '0) ? 64 : cfg_timeout / 3 + 1;
      phase_base = active_items;
      seq_left = 0;
      paused = 1'b0;
      if (ph == HoldPhase) begin
        // keep offering while the receiver holds off so the queue fills
        hold_req = 1'b1;
        burst_left = 200;
      end

      while (active_items - phase_base < PhaseItems) begin
        if (ph == PausePhase && !paused && active_items - phase_base >= PhaseItems / 2) begin
          paused = 1'b1;
          drain_all();
        end
        if (burst_left == 0) begin
          idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if ($urandom_range(0, 19) == 0) begin
          // noise: arbitrary command, level and timer
          it.cmd        = 1'($urandom_range(0, 1));
          it.tach_level = 1'($urandom_range(0, 1));
          it.timer_ns   = rand_timer();
        end else if (seq_left == 0) begin
          cur_level = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 7) == 0) cur_time = TimerMax - TimerW'($urandom_range(0, 1000));
          else cur_time = rand_timer();
          seq_left = (cfg_edge_limit > 18) ? 40 : 2 * cfg_edge_limit + 4;
          seq_left = $urandom_range(1, seq_left);
          it.cmd        = 1'b1;
          it.tach_level = cur_level;
          it.timer_ns   = cur_time;
        end else begin
          if ($urandom_range(0, 9) != 0)
            cur_time = cur_time + TimerW'($urandom_range(0, step_max));
          if ($urandom_range(0, 9) < 7) cur_level = ~cur_level;
          seq_left--;
          it.cmd        = 1'b0;
          it.tach_level = cur_level;
          it.timer_ns   = cur_time;
        end
        send_item(it, 1'b0, '0);
      end
    end

    drain_all();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
